[rtl/routing_usage_tile_histogram_defines.svh]
// Assertion macros shared by the histogram checker.
`ifndef ROUTING_USAGE_TILE_HISTOGRAM_DEFINES_SVH
`define ROUTING_USAGE_TILE_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RUTH_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ruth check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RUTH_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ruth check failed");

`endif

[rtl/ruth_pkg.sv]
// Types and constants of the routing usage tile histogram.
package ruth_pkg;

	localparam int COORD_W = 24;
	localparam int SIZE_W = 16;
	localparam int TILES_W = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int USAGE_W = 35;
	localparam int IN_DATA_W = 112;
	localparam int OUT_DATA_W = 72;

	// Command codes (s_tuser)
	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Status codes (m_tuser)
	localparam logic [1:0] ST_COUNTED = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_W = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_H = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TILES_ACROSS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TILES_DOWN = 3'd5;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b00_0000_0001,
		S_IDLE = 10'b00_0000_0010,
		S_DIV = 10'b00_0000_0100,
		S_RD = 10'b00_0000_1000,
		S_UPD = 10'b00_0001_0000,
		S_LRD = 10'b00_0010_0000,
		S_LACC = 10'b00_0100_0000,
		S_MUL = 10'b00_1000_0000,
		S_FIN = 10'b01_0000_0000,
		S_SPARE = 10'b10_0000_0000
	} state_t;

	// Divider handshake
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic done;
	} div_sts_t;

endpackage

[rtl/ruth_div.sv]
// Serial restoring divider, one quotient bit per cycle.
module ruth_div
	import ruth_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  div_ctl_t           ctl,
	input  logic [COORD_W-1:0] dividend,
	input  logic [SIZE_W-1:0]  divisor,
	output div_sts_t           sts,
	output logic [COORD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(COORD_W + 1);

	logic [SIZE_W-1:0]  rem_q;
	logic [COORD_W-1:0] quo_q;
	logic [SIZE_W-1:0]  dsr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [SIZE_W:0]    shifted;
	logic [SIZE_W:0]    trial;

	// Form the partial remainder and trial subtract
	always_comb begin
		shifted = {rem_q, quo_q[COORD_W-1]};
		trial = shifted - {1'b0, dsr_q};
	end

	// Step one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(COORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[SIZE_W]) begin
				rem_q <= trial[SIZE_W-1:0];
				quo_q <= {quo_q[COORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[SIZE_W-1:0];
				quo_q <= {quo_q[COORD_W-2:0], 1'b0};
			end
		end
	end

	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule

[rtl/ruth_mem.sv]
// Counter store: one write port, one registered read port.
module ruth_mem
	import ruth_pkg::*;
#(
	parameter int DEPTH = 32768,
	parameter int AW = 15,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/routing_usage_tile_histogram.sv]
// Top level of the routing usage tile histogram.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tuser command, tdata track or tile
//  m_*     | out | m_tvalid/m_tready  | tuser status, tdata usages
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
// An add-track request sends four tile indices one after another through the
// serial divider, one quotient bit per cycle, then reads, bumps and writes the
// counters. A readout reads one counter per layer on each store port.
// After reset a clearing pass writes zero to MAX_COLUMNS x MAX_ROWS x LAYERS
// entries, one a cycle, with s_tready low. A stalled result holds in the
// output register; the next request waits for it only at its end.
module routing_usage_tile_histogram
	import ruth_pkg::*;
#(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS = 64,
	parameter int LAYERS = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  s_tuser,  // command
	// end_a_x, end_a_y, end_b_x, end_b_y, layer_number, read_column, read_row
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [1:0]            m_tuser,  // status
	// usage_horizontal, usage_vertical, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS * LAYERS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int SW = COUNT_BITS + $clog2(LAYERS + 1);
	localparam int PW = SW + SIZE_W;
	localparam int EW = (PW > USAGE_W) ? PW : USAGE_W + 1;
	localparam int LIM_W = 11;

	// Configuration
	logic [COORD_W-1:0] origin_x_q, origin_y_q;
	logic [SIZE_W-1:0]  tile_w_q, tile_h_q;
	logic [TILES_W-1:0] across_q, down_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			tile_w_q <= SIZE_W'(1);
			tile_h_q <= SIZE_W'(1);
			across_q <= TILES_W'(64);
			down_q <= TILES_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Y: origin_y_q <= cfg_data;
				REG_TILE_W: tile_w_q <= cfg_data[SIZE_W-1:0];
				REG_TILE_H: tile_h_q <= cfg_data[SIZE_W-1:0];
				REG_TILES_ACROSS: across_q <= cfg_data[TILES_W-1:0];
				REG_TILES_DOWN: down_q <= cfg_data[TILES_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective grid size
	logic [LIM_W-1:0] ncol, nrow;
	always_comb begin
		ncol = (LIM_W'(across_q) < LIM_W'(MAX_COLUMNS)) ? LIM_W'(across_q) : LIM_W'(MAX_COLUMNS);
		nrow = (LIM_W'(down_q) < LIM_W'(MAX_ROWS)) ? LIM_W'(down_q) : LIM_W'(MAX_ROWS);
	end

	// Unpack the request
	logic [COORD_W-1:0] ax, ay, bx, by, lox, hix, loy, hiy;
	logic [3:0] layer_in;
	logic [5:0] rcol_in, rrow_in;
	logic add_err, read_err;
	always_comb begin
		ax = s_tdata[23:0];
		ay = s_tdata[47:24];
		bx = s_tdata[71:48];
		by = s_tdata[95:72];
		layer_in = s_tdata[99:96];
		rcol_in = s_tdata[105:100];
		rrow_in = s_tdata[111:106];
		lox = (ax < bx) ? ax : bx;
		hix = (ax < bx) ? bx : ax;
		loy = (ay < by) ? ay : by;
		hiy = (ay < by) ? by : ay;
		add_err = (layer_in == 4'd0) || (5'(layer_in) > 5'(LAYERS))
			|| (tile_w_q == '0) || (tile_h_q == '0)
			|| (lox < origin_x_q) || (loy < origin_y_q);
		read_err = (LIM_W'(rcol_in) >= ncol) || (LIM_W'(rrow_in) >= nrow);
	end

	state_t state_q;
	logic [COORD_W-1:0] diff_q [4];
	logic [1:0] k_q;
	logic horiz_q;
	logic [LW-1:0] layer_q, lcnt_q;
	logic [CW-1:0] lc_q, uc_q;
	logic [RW-1:0] lr_q, ur_q;
	logic [AW-1:0] clr_q;
	logic [1:0] res_st_q;
	logic [SW-1:0] sum_h_q, sum_v_q;
	logic [PW-1:0] prod_h_q, prod_v_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0] m_tuser_q;
	logic m_tvalid_q;
	div_ctl_t div_ctl_q;
	div_sts_t div_sts;
	logic [COORD_W-1:0] quo;

	ruth_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(div_ctl_q),
		.dividend(diff_q[k_q]),
		.divisor(k_q[0] ? tile_h_q : tile_w_q),
		.sts(div_sts),
		.quotient(quo)
	);

	// Store addresses
	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
		input logic [CW-1:0] col, input logic [LW-1:0] lay);
		cell_addr = AW'((AW'(row) * AW'(MAX_COLUMNS) + AW'(col)) * AW'(LAYERS) + AW'(lay));
	endfunction

	logic [AW-1:0] lo_addr, hi_addr, rd_addr, wa_right, wa_left, ra_right, ra_left;
	logic readout;
	always_comb begin
		lo_addr = cell_addr(lr_q, lc_q, layer_q);
		hi_addr = cell_addr(ur_q, uc_q, layer_q);
		rd_addr = cell_addr(lr_q, lc_q, lcnt_q);
		readout = (state_q == S_LRD) || (state_q == S_LACC);
		wa_right = (state_q == S_CLEAR) ? clr_q : lo_addr;
		wa_left = (state_q == S_CLEAR) ? clr_q : hi_addr;
		ra_right = readout ? rd_addr : lo_addr;
		ra_left = readout ? rd_addr : hi_addr;
	end

	logic [COUNT_BITS-1:0] hl_rd, hr_rd, vl_rd, vr_rd;
	logic [COUNT_BITS-1:0] hl_wd, hr_wd, vl_wd, vr_wd;
	logic we_h, we_v, clearing;

	// Saturating bumps, zero during the clearing pass
	always_comb begin
		clearing = (state_q == S_CLEAR);
		we_h = clearing || ((state_q == S_UPD) && horiz_q);
		we_v = clearing || ((state_q == S_UPD) && !horiz_q);
		hl_wd = (clearing || &hl_rd) ? (clearing ? '0 : hl_rd) : hl_rd + 1'b1;
		hr_wd = (clearing || &hr_rd) ? (clearing ? '0 : hr_rd) : hr_rd + 1'b1;
		vl_wd = (clearing || &vl_rd) ? (clearing ? '0 : vl_rd) : vl_rd + 1'b1;
		vr_wd = (clearing || &vr_rd) ? (clearing ? '0 : vr_rd) : vr_rd + 1'b1;
	end

	ruth_mem #(.DEPTH(DEPTH), .AW(AW), .DW(COUNT_BITS)) u_hl (
		.clk(clk), .we(we_h), .waddr(wa_left), .wdata(hl_wd),
		.raddr(ra_left), .rdata(hl_rd));
	ruth_mem #(.DEPTH(DEPTH), .AW(AW), .DW(COUNT_BITS)) u_hr (
		.clk(clk), .we(we_h), .waddr(wa_right), .wdata(hr_wd),
		.raddr(ra_right), .rdata(hr_rd));
	ruth_mem #(.DEPTH(DEPTH), .AW(AW), .DW(COUNT_BITS)) u_vl (
		.clk(clk), .we(we_v), .waddr(wa_left), .wdata(vl_wd),
		.raddr(ra_left), .rdata(vl_rd));
	ruth_mem #(.DEPTH(DEPTH), .AW(AW), .DW(COUNT_BITS)) u_vr (
		.clk(clk), .we(we_v), .waddr(wa_right), .wdata(vr_wd),
		.raddr(ra_right), .rdata(vr_rd));

	// Saturate the scaled usages
	logic [USAGE_W-1:0] use_h, use_v;
	logic [EW-1:0] ext_h, ext_v;
	logic out_free;
	always_comb begin
		ext_h = EW'(prod_h_q);
		ext_v = EW'(prod_v_q);
		use_h = (|ext_h[EW-1:USAGE_W]) ? '1 : ext_h[USAGE_W-1:0];
		use_v = (|ext_v[EW-1:USAGE_W]) ? '1 : ext_v[USAGE_W-1:0];
		out_free = !m_tvalid_q || m_tready;
	end

	logic [LIM_W-1:0] limit;
	logic idx_ok;
	always_comb begin
		limit = k_q[0] ? nrow : ncol;
		idx_ok = quo < COORD_W'(limit);
	end

	// Launch a division on an accepted track and after each in-range quotient but the last
	logic div_start;
	always_comb begin
		div_start = ((state_q == S_IDLE) && s_tvalid && (s_tuser == CMD_ADD) && !add_err)
			|| ((state_q == S_DIV) && div_sts.done && idx_ok && (k_q != 2'd3));
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			k_q <= '0;
			lcnt_q <= '0;
			div_ctl_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			div_ctl_q.start <= div_start;
			// Raise valid when a result is loaded, drop it once taken
			if ((state_q == S_FIN) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						k_q <= '0;
						lcnt_q <= '0;
						if (s_tuser == CMD_READ) begin
							state_q <= read_err ? S_FIN : S_LRD;
						end else if (add_err) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_sts.done) begin
						if (!idx_ok) begin
							state_q <= S_FIN;
						end else if (k_q == 2'd3) begin
							state_q <= S_RD;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_RD: state_q <= S_UPD;
				S_UPD: state_q <= S_FIN;
				S_LRD: state_q <= S_LACC;
				S_LACC: begin
					lcnt_q <= lcnt_q + 1'b1;
					state_q <= (lcnt_q == LW'(LAYERS - 1)) ? S_MUL : S_LRD;
				end
				S_MUL: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				diff_q[0] <= lox - origin_x_q;
				diff_q[1] <= loy - origin_y_q;
				diff_q[2] <= hix - origin_x_q;
				diff_q[3] <= hiy - origin_y_q;
				horiz_q <= (ay == by);
				layer_q <= LW'(layer_in - 4'd1);
				lc_q <= CW'(rcol_in);
				lr_q <= RW'(rrow_in);
				sum_h_q <= '0;
				sum_v_q <= '0;
				prod_h_q <= '0;
				prod_v_q <= '0;
				if (s_tuser == CMD_READ) begin
					res_st_q <= read_err ? ST_RANGE : ST_READ;
				end else begin
					res_st_q <= ST_RANGE;
				end
			end
			S_DIV: begin
				if (div_sts.done) begin
					case (k_q)
						2'd0: lc_q <= CW'(quo);
						2'd1: lr_q <= RW'(quo);
						2'd2: uc_q <= CW'(quo);
						default: ur_q <= RW'(quo);
					endcase
				end
			end
			S_UPD: res_st_q <= ST_COUNTED;
			S_LACC: begin
				sum_h_q <= sum_h_q + SW'((hl_rd > hr_rd) ? hl_rd : hr_rd);
				sum_v_q <= sum_v_q + SW'((vl_rd > vr_rd) ? vl_rd : vr_rd);
			end
			S_MUL: begin
				prod_h_q <= PW'(sum_h_q) * PW'(tile_w_q);
				prod_v_q <= PW'(sum_v_q) * PW'(tile_h_q);
			end
			S_FIN: begin
				if (out_free) begin
					m_tuser_q <= res_st_q;
					if (res_st_q == ST_READ) begin
						m_tdata_q <= {2'b00, use_v, use_h};
					end else begin
						m_tdata_q <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser = m_tuser_q;
	assign m_tdata = m_tdata_q;

endmodule

[rtl/ruth_chk.sv]
// Port checker for the routing usage tile histogram, bound to the top level.
`include "routing_usage_tile_histogram_defines.svh"

module ruth_chk
	import ruth_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [1:0]            m_tuser,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// Usages are zero unless the readout was valid
	`RUTH_ASSERT_IMP(a_zero_usage, m_tvalid && (m_tuser != ST_READ), m_tdata == '0)
	// One request at a time: ready drops right after an accept
	`RUTH_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
	// A stalled result holds
	`RUTH_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind routing_usage_tile_histogram ruth_chk u_ruth_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tuser(m_tuser),
	.m_tdata(m_tdata)
);

[dv/routing_usage_tile_histogram_test.sv]
// Self-checking testbench of the routing usage tile histogram.
`timescale 1ns / 100ps

module routing_usage_tile_histogram_test;
	import ruth_pkg::*;

	localparam int COLS = 64;
	localparam int ROWS = 64;
	localparam int NLAYERS = 8;
	localparam int DEPTH = COLS * ROWS * NLAYERS;
	localparam int STALL_LIMIT = 200000;
	localparam logic [USAGE_W-1:0] USAGE_TOP = {USAGE_W{1'b1}};
	// Register indexes that map to no register
	localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

	typedef struct {
		logic [1:0]         status;
		logic [USAGE_W-1:0] horiz;
		logic [USAGE_W-1:0] vert;
	} usage_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic s_tuser;
	logic [IN_DATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [1:0] m_tuser;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the counters and registers
	bit [15:0] hl_cnt [DEPTH];
	bit [15:0] hr_cnt [DEPTH];
	bit [15:0] vl_cnt [DEPTH];
	bit [15:0] vr_cnt [DEPTH];
	bit [23:0] org_x, org_y;
	bit [15:0] tile_w, tile_h;
	bit [6:0] across, down;

	usage_result_t usage_queue[$];
	int errors;
	int sender_idle;
	int receiver_idle;
	int quiet_cycles;

	routing_usage_tile_histogram u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Tile index of one coordinate; returns 0 when outside the grid
	function automatic bit tile_of(bit [23:0] coord, bit [23:0] origin, bit [15:0] size,
			int limit, output int idx);
		int unsigned q;
		idx = 0;
		if (size == 0 || coord < origin) return 1'b0;
		q = (coord - origin) / size;
		if (q >= limit) return 1'b0;
		idx = q;
		return 1'b1;
	endfunction

	function automatic bit [15:0] bump(bit [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [USAGE_W-1:0] scale_usage(longint unsigned sum, bit [15:0] size);
		longint unsigned prod;
		prod = sum * size;
		return (prod > USAGE_TOP) ? USAGE_TOP : prod[USAGE_W-1:0];
	endfunction

	// Update the shadow counters for one request and return the expected result
	function automatic usage_result_t predict_usage(logic cmd, logic [IN_DATA_W-1:0] d);
		usage_result_t r;
		int ncol, nrow, lc, lr, uc, ur, lo, hi, cidx;
		bit [23:0] ax, ay, bx, by;
		bit [3:0] layer;
		bit ok;
		longint unsigned sh, sv;
		ncol = (across < COLS) ? across : COLS;
		nrow = (down < ROWS) ? down : ROWS;
		r.status = ST_RANGE;
		r.horiz = '0;
		r.vert = '0;
		ax = d[23:0];
		ay = d[47:24];
		bx = d[71:48];
		by = d[95:72];
		layer = d[99:96];
		if (cmd == CMD_ADD) begin
			if (layer == 0 || layer > NLAYERS) return r;
			ok = tile_of((ax < bx) ? ax : bx, org_x, tile_w, ncol, lc);
			ok &= tile_of((ay < by) ? ay : by, org_y, tile_h, nrow, lr);
			ok &= tile_of((ax < bx) ? bx : ax, org_x, tile_w, ncol, uc);
			ok &= tile_of((ay < by) ? by : ay, org_y, tile_h, nrow, ur);
			if (!ok) return r;
			lo = (lr * COLS + lc) * NLAYERS + layer - 1;
			hi = (ur * COLS + uc) * NLAYERS + layer - 1;
			if (ay == by) begin
				hr_cnt[lo] = bump(hr_cnt[lo]);
				hl_cnt[hi] = bump(hl_cnt[hi]);
			end else begin
				vr_cnt[lo] = bump(vr_cnt[lo]);
				vl_cnt[hi] = bump(vl_cnt[hi]);
			end
			r.status = ST_COUNTED;
			return r;
		end
		if (d[105:100] >= ncol || d[111:106] >= nrow) return r;
		sh = 0;
		sv = 0;
		for (int l = 0; l < NLAYERS; l++) begin
			cidx = (d[111:106] * COLS + d[105:100]) * NLAYERS + l;
			sh += (hl_cnt[cidx] > hr_cnt[cidx]) ? hl_cnt[cidx] : hr_cnt[cidx];
			sv += (vl_cnt[cidx] > vr_cnt[cidx]) ? vl_cnt[cidx] : vr_cnt[cidx];
		end
		r.status = ST_READ;
		r.horiz = scale_usage(sh, tile_w);
		r.vert = scale_usage(sv, tile_h);
		return r;
	endfunction

	// Present one request, hold it until accepted, predict its result
	task automatic send_request(logic cmd, logic [IN_DATA_W-1:0] d);
		usage_result_t want_r;
		if (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		want_r = predict_usage(cmd, d);
		usage_queue = {usage_queue, want_r};
	endtask

	task automatic send_track(bit [23:0] ax, bit [23:0] ay, bit [23:0] bx, bit [23:0] by,
			bit [3:0] layer);
		logic [IN_DATA_W-1:0] d;
		d = '0;
		d[23:0] = ax;
		d[47:24] = ay;
		d[71:48] = bx;
		d[95:72] = by;
		d[99:96] = layer;
		d[111:100] = 12'($urandom);
		send_request(CMD_ADD, d);
	endtask

	task automatic send_readout(bit [5:0] col, bit [5:0] row);
		logic [IN_DATA_W-1:0] d;
		d = IN_DATA_W'({$urandom, $urandom, $urandom, $urandom});
		d[105:100] = col;
		d[111:106] = row;
		send_request(CMD_READ, d);
	endtask

	// Drop valid and wait until every result has come back
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (usage_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Drive one register write for a cycle; the caller drops the enable
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_ORIGIN_X: org_x = val;
			REG_ORIGIN_Y: org_y = val;
			REG_TILE_W: tile_w = val[15:0];
			REG_TILE_H: tile_h = val[15:0];
			REG_TILES_ACROSS: across = val[6:0];
			REG_TILES_DOWN: down = val[6:0];
			default: ;
		endcase
	endtask

	task automatic set_grid(bit [23:0] ox, bit [23:0] oy, bit [15:0] w, bit [15:0] h,
			bit [6:0] nx, bit [6:0] ny);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_TILE_W, CFG_DATA_W'(w));
		write_reg(REG_TILE_H, CFG_DATA_W'(h));
		write_reg(REG_TILES_ACROSS, CFG_DATA_W'(nx));
		write_reg(REG_TILES_DOWN, CFG_DATA_W'(ny));
		cfg_we <= 1'b0;
	endtask

	// Reset grid: unit tiles, full 64 x 64
	task automatic test_default_grid;
		send_track(24'd0, 24'd5, 24'd3, 24'd5, 4'd1);
		send_track(24'd3, 24'd5, 24'd0, 24'd5, 4'd1);
		send_track(24'd2, 24'd9, 24'd2, 24'd0, 4'd8);
		send_track(24'd63, 24'd63, 24'd0, 24'd0, 4'd4);
		send_track(24'd1, 24'd1, 24'd2, 24'd2, 4'd0);
		send_track(24'd1, 24'd1, 24'd2, 24'd2, 4'd9);
		send_track(24'd1, 24'd1, 24'd2, 24'd2, 4'd15);
		send_track(24'd64, 24'd1, 24'd2, 24'd1, 4'd2);
		send_track(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'd3);
		send_readout(6'd0, 6'd5);
		send_readout(6'd3, 6'd5);
		send_readout(6'd2, 6'd0);
		send_readout(6'd63, 6'd63);
		send_readout(6'd0, 6'd0);
		drain();
	endtask

	// Extreme register values, zero sizes and counts, unknown indexes
	task automatic test_register_extremes;
		write_reg(REG_NONE_LO, 24'hFFFFFF);
		write_reg(REG_NONE_HI, 24'h000000);
		set_grid(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 7'd64, 7'd64);
		send_track(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'd8);
		send_track(24'hFFFFFE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 4'd8);
		send_readout(6'd0, 6'd0);
		drain();
		set_grid(24'd100, 24'd200, 16'd0, 16'd7, 7'd3, 7'd127);
		send_track(24'd100, 24'd200, 24'd101, 24'd200, 4'd1);
		send_readout(6'd0, 6'd0);
		send_readout(6'd3, 6'd0);
		send_readout(6'd2, 6'd63);
		drain();
		set_grid(24'd0, 24'd0, 16'd1, 16'd1, 7'd0, 7'd1);
		send_track(24'd0, 24'd0, 24'd0, 24'd0, 4'd1);
		send_readout(6'd0, 6'd0);
		drain();
		set_grid(24'd0, 24'd0, 16'd1, 16'd1, 7'd1, 7'd1);
		send_track(24'd0, 24'd0, 24'd0, 24'd0, 4'd5);
		send_readout(6'd0, 6'd0);
		drain();
	endtask

	// Random grid, then mostly well-formed tracks with readouts and noise
	task automatic test_random_traffic(int count);
		int span_x, span_y;
		bit [23:0] ax, ay, bx, by;
		bit [3:0] layer;
		set_grid(24'($urandom_range(0, 1 << 20)), 24'($urandom_range(0, 1 << 20)),
			16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
			7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
		span_x = ((across < COLS) ? across : COLS) * tile_w;
		span_y = ((down < ROWS) ? down : ROWS) * tile_h;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0, 1, 2: send_readout(6'($urandom_range(0, 63) % (across + 2)),
					6'($urandom_range(0, 63) % (down + 2)));
				3: send_track(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
					4'($urandom));
				default: begin
					ax = 24'(org_x + $urandom_range(0, span_x));
					ay = 24'(org_y + $urandom_range(0, span_y - 1));
					bx = $urandom_range(1) ? ax : 24'(org_x + $urandom_range(0, span_x - 1));
					by = (bx == ax) ? 24'(org_y + $urandom_range(0, span_y)) : ay;
					layer = ($urandom_range(15) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
					send_track(ax, ay, bx, by, layer);
				end
			endcase
		end
		drain();
	endtask

	// Receiver side back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_idle);
		end
	end

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		usage_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (usage_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected result status %0d h %0d v %0d", $time, m_tuser,
					m_tdata[34:0], m_tdata[69:35]);
			end else begin
				want = usage_queue.pop_front();
				if (m_tuser !== want.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
				end
				if (m_tdata[34:0] !== want.horiz) begin
					errors++;
					$display("%0t: usage_horizontal expected %0d actual %0d", $time,
						want.horiz, m_tdata[34:0]);
				end
				if (m_tdata[69:35] !== want.vert) begin
					errors++;
					$display("%0t: usage_vertical expected %0d actual %0d", $time,
						want.vert, m_tdata[69:35]);
				end
				if (m_tdata[71:70] !== 2'b00) begin
					errors++;
					$display("%0t: fill bits expected 0 actual %0d", $time, m_tdata[71:70]);
				end
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("routing_usage_tile_histogram test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		errors = 0;
		sender_idle = 31;
		receiver_idle = 68;
		org_x = 0;
		org_y = 0;
		tile_w = 1;
		tile_h = 1;
		across = 64;
		down = 64;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = CMD_ADD;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ORIGIN_X;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_grid();
		test_register_extremes();
		for (int p = 0; p < 3; p++) test_random_traffic(70);
		sender_idle = 68;
		receiver_idle = 31;
		for (int p = 0; p < 3; p++) test_random_traffic(70);
		sender_idle = 0;
		receiver_idle = 0;
		for (int p = 0; p < 3; p++) test_random_traffic(70);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("routing_usage_tile_histogram test passed");
		end else begin
			$display("routing_usage_tile_histogram test failed");
		end
		$finish;
	end

endmodule
